// ===== rtl/vfpr_pkg.sv =====
// Package with shared types and constants for the virtual file pattern reader.
`timescale 1ns / 1ps

package vfpr_pkg;

  localparam int MAX_RESULTS = 64;
  localparam int WORD_BYTES = 8;

  localparam logic [1:0] REG_FILE_SIZE   = 2'd0;
  localparam logic [1:0] REG_RANDOM_MODE = 2'd1;
  localparam logic [1:0] REG_INODE_SEED  = 2'd2;

  localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
  localparam logic [63:0] LCG_INC = 64'd1442695040888963407;
  localparam int TOP_SHIFT = 56;

  typedef struct packed {
    logic load;
    logic clip;
    logic mul;
    logic add;
    logic zero_word;
  } vfpr_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic random;
    logic rem_le1;
    logic rem_le8;
  } vfpr_status_t;

endpackage

// ===== rtl/vfpr_ctrl.sv =====
// Controller state machine that sequences clipping, generator steps and word output.
`timescale 1ns / 1ps

module vfpr_ctrl
  import vfpr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  output vfpr_cmd_t    cmd,
  input  vfpr_status_t status
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CLIP = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_ZERO = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = ST_CLIP;
        end
      end
      ST_CLIP: begin
        cmd.clip = 1'b1;
        if (status.n_zero) begin
          state_next = ST_IDLE;
        end else if (status.random) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_ZERO;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        state_next = status.rem_le1 ? ST_IDLE : ST_MUL;
      end
      ST_ZERO: begin
        cmd.zero_word = 1'b1;
        if (status.rem_le8) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== rtl/vfpr_datapath.sv =====
// Datapath with configuration registers, length clipping, the LCG and word assembly.
`timescale 1ns / 1ps

module vfpr_datapath
  import vfpr_pkg::*;
#(
  parameter int MAX_REQUEST_BYTES = 512,
  parameter int OFFSET_BITS = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic [47:0]  read_offset,
  input  logic [9:0]   read_length,
  input  vfpr_cmd_t    cmd,
  output vfpr_status_t status,
  output logic         result_valid,
  output logic [63:0]  data_word,
  output logic [3:0]   byte_count,
  output logic         last_word,
  output logic [9:0]   returned_length
);

  localparam int CAP_INT = (MAX_REQUEST_BYTES < MAX_RESULTS * WORD_BYTES) ?
                           MAX_REQUEST_BYTES : MAX_RESULTS * WORD_BYTES;
  localparam logic [9:0] LEN_CAP = 10'(CAP_INT);

  logic [47:0] file_size;
  logic        random_mode;
  logic [63:0] inode_seed;

  logic [47:0] off_q;
  logic [9:0]  len_q;
  logic [63:0] gen;
  logic [9:0]  remaining;
  logic [9:0]  total;
  logic [2:0]  lane;
  logic [63:0] word_acc;
  logic [63:0] p0;
  logic [31:0] p1;
  logic [31:0] p2;

  logic [47:0] off_masked;
  logic [9:0]  len_sat;
  logic [47:0] rem_file;
  logic        past_end;
  logic [9:0]  n_clip;
  logic [63:0] prod_lo;
  logic [63:0] prod_hl;
  logic [63:0] prod_lh;
  logic [63:0] s_new;
  logic [63:0] word_new;
  logic        word_full;
  logic [3:0]  zero_cnt;

  always_comb begin
    for (int i = 0; i < 48; i++) begin
      off_masked[i] = (i < OFFSET_BITS) ? read_offset[i] : 1'b0;
    end
  end

  assign len_sat  = (read_length > LEN_CAP) ? LEN_CAP : read_length;
  assign past_end = (off_q >= file_size);
  assign rem_file = file_size - off_q;
  assign n_clip   = past_end ? 10'd0 :
                    (({38'd0, len_q} < rem_file) ? len_q : rem_file[9:0]);

  assign prod_lo  = gen[31:0] * LCG_MUL[31:0];
  assign prod_hl  = gen[63:32] * LCG_MUL[31:0];
  assign prod_lh  = gen[31:0] * LCG_MUL[63:32];
  assign s_new    = p0 + {p1 + p2, 32'd0} + LCG_INC;
  assign word_new = word_acc | ({56'd0, s_new[63:TOP_SHIFT]} << {lane, 3'b000});
  assign word_full = (lane == 3'd7) || (remaining == 10'd1);
  assign zero_cnt = (remaining < 10'd8) ? remaining[3:0] : 4'd8;

  assign status.n_zero  = (n_clip == 10'd0);
  assign status.random  = random_mode;
  assign status.rem_le1 = (remaining <= 10'd1);
  assign status.rem_le8 = (remaining <= 10'd8);

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size   <= '0;
      random_mode <= 1'b0;
      inode_seed  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FILE_SIZE:   file_size <= cfg_data[47:0];
        REG_RANDOM_MODE: random_mode <= cfg_data[0];
        REG_INODE_SEED:  inode_seed <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.clip && (n_clip == 10'd0)) || (cmd.add && word_full) ||
                      cmd.zero_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      off_q <= off_masked;
      len_q <= len_sat;
      gen   <= {16'd0, off_masked} ^ inode_seed;
    end
    if (cmd.clip) begin
      remaining <= n_clip;
      total     <= n_clip;
      lane      <= 3'd0;
      word_acc  <= '0;
      if (n_clip == 10'd0) begin
        data_word       <= '0;
        byte_count      <= 4'd0;
        last_word       <= 1'b1;
        returned_length <= 10'd0;
      end
    end
    if (cmd.mul) begin
      p0 <= prod_lo;
      p1 <= prod_hl[31:0];
      p2 <= prod_lh[31:0];
    end
    if (cmd.add) begin
      gen       <= s_new;
      remaining <= remaining - 10'd1;
      if (word_full) begin
        word_acc        <= '0;
        lane            <= 3'd0;
        data_word       <= word_new;
        byte_count      <= {1'b0, lane} + 4'd1;
        last_word       <= (remaining == 10'd1);
        returned_length <= total;
      end else begin
        word_acc <= word_new;
        lane     <= lane + 3'd1;
      end
    end
    if (cmd.zero_word) begin
      remaining       <= remaining - {6'd0, zero_cnt};
      data_word       <= '0;
      byte_count      <= zero_cnt;
      last_word       <= (remaining <= 10'd8);
      returned_length <= total;
    end
  end

endmodule

// ===== rtl/virtual_file_pattern_reader_top.sv =====
// Top level of the virtual file pattern reader: controller plus datapath.
// The clip step runs in the cycle after start; an empty read strobes its word, registered
// from the clip step. Random mode spends a multiply step and an add step per byte on the
// three-multiplier LCG, packing up to eight bytes per word. Zero mode strobes one word per
// cycle. The receiver cannot stall; busy drops with the final word. Synchronous reset
// clears the configuration registers, the state and strobe.
`timescale 1ns / 1ps

module virtual_file_pattern_reader_top
  import vfpr_pkg::*;
#(
  parameter int MAX_REQUEST_BYTES = 512,
  parameter int OFFSET_BITS = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [47:0] read_offset,
  input  logic [9:0]  read_length,
  output logic        result_valid,
  output logic [63:0] data_word,
  output logic [3:0]  byte_count,
  output logic        last_word,
  output logic [9:0]  returned_length
);

  vfpr_cmd_t    cmd;
  vfpr_status_t status;

  vfpr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  vfpr_datapath #(
    .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .read_offset     (read_offset),
    .read_length     (read_length),
    .cmd             (cmd),
    .status          (status),
    .result_valid    (result_valid),
    .data_word       (data_word),
    .byte_count      (byte_count),
    .last_word       (last_word),
    .returned_length (returned_length)
  );

endmodule
